// File: design/fcf_pkg.sv
// Package for the drop-tail queue with congestion feedback.
// Types, sizes and codes shared by the front, back, config and checker files.
// No dependencies.
package fcf_pkg;

	localparam int DEPTH    = 256;
	localparam int TAG_BITS = 16;
	localparam int PTR_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int LIM_W    = 9;
	localparam int PCT_W    = 7;
	localparam int BYTES_W  = 16;
	localparam int PROD_W   = 16;
	localparam int ADDR_W   = 3;

	localparam logic [BYTES_W-1:0] FB_BYTES    = 16'd20;
	localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
	localparam logic [LIM_W-1:0]   LIMIT_RST   = 9'd256;
	localparam logic [PCT_W-1:0]   RELEASE_RST = 7'd85;

	localparam logic REG_LIMIT   = 1'b0;
	localparam logic REG_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		OUT_QUEUED  = 2'd0,
		OUT_DROPPED = 2'd1,
		OUT_SENT    = 2'd2,
		OUT_EMPTY   = 2'd3
	} outcome_t;

	typedef struct packed {
		logic                is_send;
		logic [TAG_BITS-1:0] tag;
		logic [BYTES_W-1:0]  bytes;
	} cmd_t;

	typedef struct packed {
		logic                is_fb;
		logic                cong;
		logic [TAG_BITS-1:0] tag;
		logic [BYTES_W-1:0]  bytes;
	} entry_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ON   = 5'b00010,
		ST_APP  = 5'b00100,
		ST_RD   = 5'b01000,
		ST_REL  = 5'b10000
	} state_t;

endpackage

// File: design/fcf_if.sv
// Request and result channel interfaces: valid/ready plus payload.
// Depends on fcf_pkg.
interface fcf_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [fcf_pkg::TAG_BITS-1:0] pkt_tag;
	logic [fcf_pkg::BYTES_W-1:0]  pkt_bytes;

	modport source(output valid, req_type, pkt_tag, pkt_bytes, input ready);
	modport sink(input valid, req_type, pkt_tag, pkt_bytes, output ready);
endinterface

interface fcf_res_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   outcome;
	logic                         out_is_feedback;
	logic                         out_congestion;
	logic [fcf_pkg::TAG_BITS-1:0] out_tag;
	logic [fcf_pkg::BYTES_W-1:0]  out_bytes;
	logic [8:0]                   fill_level;
	logic                         congested;

	modport source(output valid, outcome, out_is_feedback, out_congestion, out_tag,
		out_bytes, fill_level, congested, input ready);
	modport sink(input valid, outcome, out_is_feedback, out_congestion, out_tag,
		out_bytes, fill_level, congested, output ready);
endinterface

// File: design/fcf_cfg.sv
// APB-style register block: buffer limit and release percentage.
// Depends on fcf_pkg.
module fcf_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fcf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [fcf_pkg::LIM_W-1:0]  limit,
	output logic [fcf_pkg::PCT_W-1:0]  release_pct
);

	logic [fcf_pkg::LIM_W-1:0] limit_q;
	logic [fcf_pkg::PCT_W-1:0] release_q;
	logic                      wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= fcf_pkg::LIMIT_RST;
			release_q <= fcf_pkg::RELEASE_RST;
		end else if (wr) begin
			if (paddr[2] == fcf_pkg::REG_LIMIT) begin
				limit_q <= pwdata[fcf_pkg::LIM_W-1:0];
			end else begin
				release_q <= pwdata[fcf_pkg::PCT_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == fcf_pkg::REG_LIMIT) begin
			prdata = {{(32 - fcf_pkg::LIM_W){1'b0}}, limit_q};
		end else begin
			prdata = {{(32 - fcf_pkg::PCT_W){1'b0}}, release_q};
		end
	end

	assign limit       = limit_q;
	assign release_pct = release_q;

endmodule

// File: design/fcf_front.sv
// Front end: takes request words, classifies them and holds them in a
// two-entry queue for the back end. Depends on fcf_pkg and fcf_if.
module fcf_front (
	input  logic          clk,
	input  logic          arst_n,
	fcf_req_if.sink       req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output fcf_pkg::cmd_t cmd
);

	fcf_pkg::cmd_t slot_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    used_q;
	logic          push;
	logic          pop;
	fcf_pkg::cmd_t in_cmd;

	assign req.ready = (used_q != 2'd2);
	assign push      = req.valid & req.ready;
	assign cmd_valid = (used_q != 2'd0);
	assign pop       = cmd_valid & cmd_ready;
	assign cmd       = slot_q[rptr_q];

	always_comb begin
		in_cmd.is_send = req.req_type;
		in_cmd.tag     = req.pkt_tag;
		in_cmd.bytes   = req.pkt_bytes;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			used_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   used_q <= used_q + 2'd1;
				2'b01:   used_q <= used_q - 2'd1;
				default: used_q <= used_q;
			endcase
		end
	end

endmodule

// File: design/fcf_back.sv
// Back end: entry store, ring pointers, congestion flag and result register.
// One memory write per cycle; feedback pushes and appends take separate steps.
// Depends on fcf_pkg and fcf_if.
module fcf_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  fcf_pkg::cmd_t             cmd,
	input  logic [fcf_pkg::LIM_W-1:0] limit,
	input  logic [fcf_pkg::PCT_W-1:0] release_pct,
	fcf_res_if.source                 res
);

	fcf_pkg::entry_t mem [fcf_pkg::DEPTH];

	fcf_pkg::state_t              state_q;
	fcf_pkg::cmd_t                cmd_q;
	logic [fcf_pkg::PTR_W-1:0]    head_q;
	logic [fcf_pkg::CNT_W-1:0]    count_q;
	logic                         flag_q;
	fcf_pkg::outcome_t            wout_q;
	logic                         sent_q;
	fcf_pkg::entry_t              rdata_q;

	logic                         res_valid_q;
	fcf_pkg::outcome_t            res_outcome_q;
	logic                         res_fb_q;
	logic                         res_cong_q;
	logic [fcf_pkg::TAG_BITS-1:0] res_tag_q;
	logic [fcf_pkg::BYTES_W-1:0]  res_bytes_q;
	logic [fcf_pkg::CNT_W-1:0]    res_fill_q;
	logic                         res_flag_q;

	logic [fcf_pkg::CNT_W-1:0]    lim_eff;
	logic [fcf_pkg::PTR_W-1:0]    head_m1;
	logic [fcf_pkg::PTR_W-1:0]    tail;
	logic                         full;
	logic                         on_hit;
	logic                         rel_hit;
	logic                         out_free;
	logic [fcf_pkg::PROD_W-1:0]   prod_cnt;
	logic [fcf_pkg::PROD_W-1:0]   prod_lim;

	logic                         we;
	logic [fcf_pkg::PTR_W-1:0]    waddr;
	fcf_pkg::entry_t              wdata;
	logic                         re;

	assign lim_eff = (limit > fcf_pkg::LIM_W'(fcf_pkg::DEPTH))
		? fcf_pkg::CNT_W'(fcf_pkg::DEPTH) : fcf_pkg::CNT_W'(limit);
	assign head_m1  = head_q - 1'b1;
	assign tail     = head_q + count_q[fcf_pkg::PTR_W-1:0];
	assign full     = (count_q == fcf_pkg::CNT_W'(fcf_pkg::DEPTH));
	assign on_hit   = (lim_eff != '0) && (count_q == lim_eff - 1'b1) && !flag_q;
	assign prod_cnt = fcf_pkg::PROD_W'(count_q) * fcf_pkg::PROD_W'(fcf_pkg::PCT_FULL);
	assign prod_lim = fcf_pkg::PROD_W'(lim_eff) * fcf_pkg::PROD_W'(release_pct);
	assign rel_hit  = flag_q && (prod_cnt <= prod_lim);
	assign out_free = !res_valid_q || res.ready;
	assign cmd_ready = (state_q == fcf_pkg::ST_IDLE);

	always_comb begin
		we          = 1'b0;
		waddr       = head_m1;
		wdata.is_fb = 1'b1;
		wdata.cong  = 1'b1;
		wdata.tag   = '0;
		wdata.bytes = fcf_pkg::FB_BYTES;
		re          = 1'b0;
		case (state_q)
			fcf_pkg::ST_ON: begin
				we = on_hit && !full;
			end
			fcf_pkg::ST_APP: begin
				we          = (count_q < lim_eff);
				waddr       = tail;
				wdata.is_fb = 1'b0;
				wdata.cong  = 1'b0;
				wdata.tag   = cmd_q.tag;
				wdata.bytes = cmd_q.bytes;
			end
			fcf_pkg::ST_RD: begin
				re = (count_q != '0);
			end
			fcf_pkg::ST_REL: begin
				we         = out_free && rel_hit && !full;
				wdata.cong = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
		if (state_q == fcf_pkg::ST_REL && out_free) begin
			res_outcome_q <= wout_q;
			res_fb_q      <= sent_q & rdata_q.is_fb;
			res_cong_q    <= sent_q & rdata_q.is_fb & rdata_q.cong;
			res_tag_q     <= (sent_q && !rdata_q.is_fb) ? rdata_q.tag : '0;
			res_bytes_q   <= sent_q ? rdata_q.bytes : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcf_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			flag_q      <= 1'b0;
			wout_q      <= fcf_pkg::OUT_QUEUED;
			sent_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_fill_q  <= '0;
			res_flag_q  <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && state_q != fcf_pkg::ST_REL) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				fcf_pkg::ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= cmd.is_send ? fcf_pkg::ST_RD : fcf_pkg::ST_ON;
					end
				end
				fcf_pkg::ST_ON: begin
					if (on_hit) begin
						flag_q <= 1'b1;
						if (!full) begin
							head_q  <= head_m1;
							count_q <= count_q + 1'b1;
						end
					end
					state_q <= fcf_pkg::ST_APP;
				end
				fcf_pkg::ST_APP: begin
					sent_q <= 1'b0;
					if (count_q >= lim_eff) begin
						wout_q <= fcf_pkg::OUT_DROPPED;
					end else begin
						wout_q  <= fcf_pkg::OUT_QUEUED;
						count_q <= count_q + 1'b1;
					end
					state_q <= fcf_pkg::ST_REL;
				end
				fcf_pkg::ST_RD: begin
					if (count_q == '0) begin
						wout_q <= fcf_pkg::OUT_EMPTY;
						sent_q <= 1'b0;
					end else begin
						wout_q  <= fcf_pkg::OUT_SENT;
						sent_q  <= 1'b1;
						head_q  <= head_q + 1'b1;
						count_q <= count_q - 1'b1;
					end
					state_q <= fcf_pkg::ST_REL;
				end
				fcf_pkg::ST_REL: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_flag_q  <= flag_q & !rel_hit;
						res_fill_q  <= (rel_hit && !full) ? count_q + 1'b1 : count_q;
						if (rel_hit) begin
							flag_q <= 1'b0;
							if (!full) begin
								head_q  <= head_m1;
								count_q <= count_q + 1'b1;
							end
						end
						state_q <= fcf_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= fcf_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid           = res_valid_q;
	assign res.outcome         = res_outcome_q;
	assign res.out_is_feedback = res_fb_q;
	assign res.out_congestion  = res_cong_q;
	assign res.out_tag         = res_tag_q;
	assign res.out_bytes       = res_bytes_q;
	assign res.fill_level      = 9'(res_fill_q);
	assign res.congested       = res_flag_q;

endmodule

// File: design/fifo_with_congestion_feedback_top.sv
// Channel   Dir   Handshake          Payload
// req       in    valid/ready        req_type, pkt_tag, pkt_bytes
// res       out   valid/ready        outcome, feedback/tag/bytes, fill_level, congested
// apb       in    psel/penable       buffer_limit @0x0, release_percent @0x4
//
// In the back end an arrival steps through take, congestion-on push, append and
// release + result, a send request through take, read and release + result; one memory write port sets this.
// Reset clears pointers, count and flag; the entry store is not cleared.
// A two-word queue in front keeps accepting, until both words are held, while the back end works or the
// result register waits on res.ready.
// Depends on fcf_pkg, fcf_if, fcf_cfg, fcf_front and fcf_back.
module fifo_with_congestion_feedback_top (
	input  logic                       clk,
	input  logic                       arst_n,
	fcf_req_if.sink                    req,
	fcf_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fcf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic                      cmd_valid;
	logic                      cmd_ready;
	fcf_pkg::cmd_t             cmd;
	logic [fcf_pkg::LIM_W-1:0] limit;
	logic [fcf_pkg::PCT_W-1:0] release_pct;

	fcf_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.limit       (limit),
		.release_pct (release_pct)
	);

	fcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	fcf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.limit       (limit),
		.release_pct (release_pct),
		.res         (res)
	);

endmodule

// File: design/fcf_chk.sv
// Port-level checker for the congestion feedback queue, bound to the top level.
// Depends on fcf_pkg.
module fcf_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [1:0]                   outcome,
	input logic                         out_is_feedback,
	input logic [fcf_pkg::TAG_BITS-1:0] out_tag,
	input logic [fcf_pkg::BYTES_W-1:0]  out_bytes,
	input logic [8:0]                   fill_level,
	input logic                         congested
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_no_send_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (outcome == fcf_pkg::OUT_QUEUED || outcome == fcf_pkg::OUT_DROPPED)
		|-> !out_is_feedback && out_tag == '0 && out_bytes == '0)
		else $error("send fields set on an arrival result");

	a_empty_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && outcome == fcf_pkg::OUT_EMPTY |-> !congested && fill_level <= 9'd1)
		else $error("empty queue left congested");

	a_fb_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && outcome == fcf_pkg::OUT_SENT && out_is_feedback
		|-> out_tag == '0 && out_bytes == fcf_pkg::FB_BYTES)
		else $error("malformed feedback word");

endmodule

bind fifo_with_congestion_feedback_top fcf_chk u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.outcome         (res.outcome),
	.out_is_feedback (res.out_is_feedback),
	.out_tag         (res.out_tag),
	.out_bytes       (res.out_bytes),
	.fill_level      (res.fill_level),
	.congested       (res.congested)
);
